/* rtl/ama_pkg.sv */
// Shared constants and payload types for the moving-average filter.
package ama_pkg;

    localparam int WINDOW        = 32;
    localparam int SAMPLE_BITS   = 12;
    localparam int WIN_LOG2      = $clog2(WINDOW);
    localparam int SUM_BITS      = SAMPLE_BITS + WIN_LOG2;
    localparam int CNT_BITS      = WIN_LOG2 + 1;
    localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [CNT_BITS-1:0]    count_t;

    typedef struct packed {
        sample_t sample;
        logic    clear;
    } ama_req_t;

    typedef struct packed {
        sample_t average;
        logic    window_full;
    } ama_rsp_t;

endpackage

/* rtl/ama_cell.sv */
// One stage of the sample delay line: holds a sample, passes it on when shifted.
module ama_cell (
    input  logic             clk,
    input  logic             shift_en,
    input  ama_pkg::sample_t d,
    output ama_pkg::sample_t q
);
    import ama_pkg::*;

    sample_t data_reg;
    sample_t data_next;

    always_comb
    begin
        data_next = shift_en ? d : data_reg;
    end

    // payload only, no reset: contents are ignored until the line has filled
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

/* rtl/ama_divider.sv */
// Restoring divider, one quotient bit per cycle: running sum over fill count.
module ama_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ama_pkg::sum_t    dividend,
    input  ama_pkg::count_t  divisor,
    output logic             done,
    output ama_pkg::sum_t    quotient
);
    import ama_pkg::*;

    sum_t                     q_reg,    q_next;
    count_t                   rem_reg,  rem_next;
    count_t                   dvs_reg,  dvs_next;
    logic [DIV_STEP_BITS-1:0] step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic [CNT_BITS:0] trial;
    logic [CNT_BITS:0] diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, q_reg[SUM_BITS-1]};
        ge        = trial >= {1'b0, dvs_reg};
        diff      = trial - {1'b0, dvs_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits back in CNT_BITS
            rem_next  = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
            q_next    = {q_reg[SUM_BITS-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_BITS'(SUM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/adc_moving_average.sv */
// Moving-average filter over the last WINDOW converter samples.
//
// Request channel (req_valid/req_ready/req) carries one sample and a clear
// flag per transaction; response channel (rsp_valid/rsp_ready/rsp) returns
// one average and a window_full flag per request, in order.
// Samples move through a chain of WINDOW cells; the last cell is the oldest
// sample and is subtracted from the running sum once the window is full.
// Result path, request to response valid:
//   clear or full window : straight to S_FINISH (sum >> log2(WINDOW))
//   window still filling : S_DIV, waiting on the bit-serial divider that
//                          divides the sum by the fill count, then S_FINISH.
// One request is in flight at a time; req_ready drops from acceptance until
// the result is moved into the output register. A finished response may
// wait in the output register while the next request is accepted. Reset
// empties the window (sum and fill count zero) and drops rsp_valid. If the
// receiver stalls, the response holds and at most one more result waits
// internally; req_ready stays low until the output register frees up.
module adc_moving_average (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ama_pkg::ama_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ama_pkg::ama_rsp_t rsp
);
    import ama_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FINISH
    } state_t;

    state_t   state_reg,     state_next;
    sum_t     sum_reg,       sum_next;
    count_t   fill_reg,      fill_next;
    sample_t  pend_avg_reg,  pend_avg_next;
    logic     pend_full_reg, pend_full_next;
    ama_rsp_t rsp_reg,       rsp_next;
    logic     rsp_valid_reg, rsp_valid_next;

    logic    accept;
    logic    shift_en;
    logic    is_full;
    logic    div_start;
    logic    div_done;
    sum_t    quotient;
    sample_t chain [WINDOW+1];

    assign accept   = req_valid && req_ready;
    assign is_full  = fill_reg == count_t'(WINDOW);
    assign shift_en = accept && !req.clear;

    assign chain[0] = sample_t'(req.sample);

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cells
        ama_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (chain[i]),
            .q        (chain[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        pend_avg_next  = pend_avg_reg;
        pend_full_next = pend_full_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        div_start      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.clear)
                    begin
                        sum_next       = '0;
                        fill_next      = '0;
                        pend_avg_next  = '0;
                        pend_full_next = 1'b0;
                        state_next     = S_FINISH;
                    end
                    else if (is_full)
                    begin
                        // oldest sample sits at the end of the chain
                        sum_next       = sum_reg + sum_t'(req.sample)
                                         - sum_t'(chain[WINDOW]);
                        pend_avg_next  = sum_next[SUM_BITS-1:WIN_LOG2];
                        pend_full_next = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        sum_next       = sum_reg + sum_t'(req.sample);
                        fill_next      = fill_reg + 1'b1;
                        pend_full_next = 1'b0;
                        div_start      = 1'b1;
                        state_next     = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pend_avg_next = quotient[SAMPLE_BITS-1:0];
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.average     = pend_avg_reg;
                    rsp_next.window_full = pend_full_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ama_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_avg_reg  <= pend_avg_next;
        pend_full_reg <= pend_full_next;
        rsp_reg       <= rsp_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // fill count never runs past the window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= count_t'(WINDOW))
        else $error("fill count exceeds window");

    // a clear empties sum and fill count
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.clear) |=> (sum_reg == '0 && fill_reg == '0))
        else $error("clear did not empty state");

    // divider only runs with a nonzero fill count
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (fill_reg != '0))
        else $error("divide by zero fill count");

    // a full-window transaction skips the divider
    a_full_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !req.clear && is_full) |=> (state_reg == S_FINISH))
        else $error("full-window transaction entered divider");

endmodule

/* test/ama_checker.sv */
// Checker for the moving-average filter: predicts each response and compares it.
module ama_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  ama_pkg::ama_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  ama_pkg::ama_rsp_t rsp,
    output int                mismatches,
    output int                awaiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import ama_pkg::*;

    sample_t             window_buf [WINDOW];
    logic [WIN_LOG2-1:0] wr_pos = '0;
    count_t              fill = '0;
    sum_t                total = '0;

    ama_rsp_t pending_averages [$];
    int       err_total = 0;
    int       queued = 0;

    assign mismatches = err_total;
    assign awaiting   = queued;

    // One slot is both the write position and the oldest entry once full.
    task automatic advance_window(input ama_req_t item, output ama_rsp_t res);
        sum_t quotient;
        res = '0;
        quotient = '0;
        if (item.clear)
        begin
            wr_pos = '0;
            fill   = '0;
            total  = '0;
        end
        else
        begin
            if (fill < WINDOW)
            begin
                fill     = fill + 1'b1;
                total    = total + item.sample;
                quotient = total / fill;
            end
            else
            begin
                total           = total - window_buf[wr_pos] + item.sample;
                quotient        = total >> WIN_LOG2;
                res.window_full = 1'b1;
            end
            window_buf[wr_pos] = item.sample;
            wr_pos             = wr_pos + 1'b1;
            res.average        = quotient[SAMPLE_BITS-1:0];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ama_rsp_t want;
        ama_rsp_t got;
        if (!rst_n)
        begin
            wr_pos = '0;
            fill   = '0;
            total  = '0;
            pending_averages.delete();
            queued = 0;
        end
        else
        begin
            // responses first; a request never completes in the edge it is taken
            if (rsp_valid && rsp_ready)
            begin
                if (pending_averages.size() == 0)
                begin
                    $display("%0t: response with none outstanding: average %0d window_full %0b",
                             $time, rsp.average, rsp.window_full);
                    err_total++;
                end
                else
                begin
                    want = pending_averages.pop_front();
                    got  = rsp;
                    if (got.average !== want.average)
                    begin
                        $display("%0t: average expected %0d actual %0d",
                                 $time, want.average, got.average);
                        err_total++;
                    end
                    if (got.window_full !== want.window_full)
                    begin
                        $display("%0t: window_full expected %0b actual %0b",
                                 $time, want.window_full, got.window_full);
                        err_total++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                advance_window(req, want);
                pending_averages.push_back(want);
            end
            queued = pending_averages.size();
        end
    end

endmodule

/* test/tb_adc_moving_average.sv */
// Testbench top for the moving-average filter: stimulus, flow control and verdict.
module tb_adc_moving_average;
    timeunit 1ns;
    timeprecision 1ps;
    import ama_pkg::*;

    localparam int ITEMS_PER_PHASE = 205;
    localparam int QUIET_LIMIT     = 4000;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam logic [11:0] MAX_SAMPLE = 12'hFFF;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     rsp_ready = 1'b0;
    ama_req_t req       = '0;
    logic     req_ready;
    logic     rsp_valid;
    ama_rsp_t rsp;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_rsp     = 1'b0;
    int quiet_cycles = 0;
    int mismatches;
    int awaiting;

    adc_moving_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ama_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp && !held)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                held = 1'b1;
            end
            else
                rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Leaves valid high on return; the next call changes payload or drops it.
    task automatic send_sample(input logic [11:0] value, input logic clr);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{sample: value, clear: clr};
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic random_samples(input int count);
        int          pick;
        logic [11:0] value;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                value = '0;
            else if (pick < 20)
                value = MAX_SAMPLE;
            else
                value = 12'($urandom);
            // clears are rare so the window regularly fills up between them
            send_sample(value, $urandom_range(99) < 3);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_sample(12'h000, 1'b0);
        send_sample(MAX_SAMPLE, 1'b0);
        send_sample(12'h001, 1'b0);
        send_sample(MAX_SAMPLE, 1'b1);   // clear ignores the sample
        send_sample(MAX_SAMPLE, 1'b0);
        send_sample(12'hAAA, 1'b0);
        send_sample(12'h555, 1'b0);
        send_sample(12'h800, 1'b0);
        send_sample(12'h7FF, 1'b0);
        send_sample(12'h000, 1'b1);
        send_sample(12'h000, 1'b1);      // back-to-back clears

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 46;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 46;
                end
                default:
                begin
                    tx_idle_pct  = 16;
                    rx_stall_pct = 16;
                end
            endcase
            if (phase == 0)
            begin
                // full-scale run: fill crossing and largest running sum
                send_sample(12'h000, 1'b1);
                repeat (40) send_sample(MAX_SAMPLE, 1'b0);
                hold_rsp = 1'b1;
            end
            random_samples(ITEMS_PER_PHASE);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (awaiting != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/ama_pkg.sv
rtl/ama_cell.sv
rtl/ama_divider.sv
rtl/adc_moving_average.sv
test/ama_checker.sv
test/tb_adc_moving_average.sv
